@@ hw/rtl/lse_pkg.sv @@
// Shared types, codes and a helper function for the logical switch evaluator.
package lse_pkg;

    localparam int SWITCH_COUNT = 16;
    localparam int INDEX_W      = 4;
    localparam int MARGIN_W     = 11;

    localparam logic [15:0]         MARKER_WORD  = 16'h8000;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 11'd16;

    localparam logic [1:0] ACT_EVALUATE = 2'd0;
    localparam logic [1:0] ACT_TICK     = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;

    localparam logic [4:0] FN_NONE   = 5'd0;
    localparam logic [4:0] FN_VEQUAL = 5'd1;
    localparam logic [4:0] FN_ALMOST = 5'd2;
    localparam logic [4:0] FN_VPOS   = 5'd3;
    localparam logic [4:0] FN_VNEG   = 5'd4;
    localparam logic [4:0] FN_APOS   = 5'd5;
    localparam logic [4:0] FN_ANEG   = 5'd6;
    localparam logic [4:0] FN_AND    = 5'd7;
    localparam logic [4:0] FN_OR     = 5'd8;
    localparam logic [4:0] FN_XOR    = 5'd9;
    localparam logic [4:0] FN_EQ     = 5'd10;
    localparam logic [4:0] FN_GT     = 5'd11;
    localparam logic [4:0] FN_LT     = 5'd12;
    localparam logic [4:0] FN_DIFF   = 5'd13;
    localparam logic [4:0] FN_ADIFF  = 5'd14;
    localparam logic [4:0] FN_TIMER  = 5'd15;
    localparam logic [4:0] FN_STICKY = 5'd16;

    typedef struct packed {
        logic [1:0]         action;
        logic [INDEX_W-1:0] switch_index;
        logic [4:0]         function_code;
        logic               and_enabled;
        logic               and_state;
        logic               first_bool;
        logic               second_bool;
        logic signed [15:0] source_value;
        logic signed [15:0] reference_value;
        logic               exact_compare;
        logic signed [7:0]  on_delay_code;
        logic signed [7:0]  off_delay_code;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] result_index;
        logic               switch_on;
    } result_t;

    // Convert a timer duration code to a tick count (at most 1800).
    function automatic logic [11:0] phase_ticks(input logic signed [7:0] code);
        logic signed [8:0] code_ext;
        logic signed [8:0] sum;
        logic [11:0]       n;
        logic [11:0]       ticks;
        code_ext = {code[7], code};
        if (code_ext < -9'sd109)
        begin
            sum   = 9'sd129 + code_ext;
            ticks = {4'b0, sum[7:0]};
        end
        else if (code_ext < 9'sd7)
        begin
            sum   = 9'sd113 + code_ext;
            n     = {4'b0, sum[7:0]};
            ticks = (n << 2) + n;
        end
        else
        begin
            sum   = 9'sd53 + code_ext;
            n     = {4'b0, sum[7:0]};
            ticks = (n << 3) + (n << 1);
        end
        return ticks;
    endfunction

endpackage

@@ hw/rtl/logical_switch_evaluator.sv @@
// Logical switch evaluator: input register, switch word file and result register.
//
// Usage:
//   Command channel: drive item and raise start; the word is taken at a rising
//   edge where start is high and busy is low. busy never rises, so one word
//   can be taken every cycle.
//   An evaluate word produces one result, registered in the result register
//   behind the evaluate stage: result and result_valid are shown for exactly
//   one cycle. Tick and clear words produce no result. The receiver cannot
//   stall the result; it must sample it in the strobe cycle.
//   Throughput is one word per cycle, set by the single read-modify-write of
//   the 16-entry switch word file in the evaluate stage; the next word sees
//   the word file as updated by the one before it.
//   Configuration channel: cfg_data is the almost-equal margin, written when
//   cfg_valid and cfg_ready are high; cfg_ready is always high. Write it only
//   while no word is in flight.
//   Reset: every switch word returns to the marker value, the margin to 16,
//   and any word in flight is dropped.
module logical_switch_evaluator
    import lse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  item_t               item,
    output logic                result_valid,
    output result_t             result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [MARGIN_W-1:0] cfg_data
);

    logic                stage_valid_reg;
    item_t               stage_item_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [15:0]         mem_reg [SWITCH_COUNT];
    logic                result_valid_reg;
    result_t             result_reg;

    logic                in_range;
    logic [15:0]         word;
    logic signed [15:0]  x;
    logic signed [15:0]  y;
    logic signed [16:0]  x_ext;
    logic signed [16:0]  y_ext;
    logic signed [16:0]  xy_diff;
    logic [16:0]         abs_xy;
    logic signed [16:0]  abs_x;
    logic [15:0]         diff_base;
    logic signed [15:0]  d;
    logic signed [16:0]  d_ext;
    logic signed [16:0]  abs_d;
    logic                diff_hit;
    logic                diff_upd;
    logic [11:0]         on_ticks;
    logic [11:0]         off_ticks;
    logic [15:0]         timer_inc;
    logic [15:0]         timer_next;
    logic [7:0]          sticky_st;
    logic [7:0]          sticky_last;
    logic                sticky_now;
    logic [15:0]         sticky_next;
    logic                gated;
    logic                eval_on;
    logic                mem_we;
    logic [15:0]         mem_wdata;
    logic                clear_all;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            stage_item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            margin_reg <= cfg_data;
        end
    end

    assign in_range = 32'(stage_item_reg.switch_index) < SWITCH_COUNT;
    assign word     = mem_reg[stage_item_reg.switch_index];
    assign x        = stage_item_reg.source_value;
    assign y        = stage_item_reg.reference_value;
    assign x_ext    = {x[15], x};
    assign y_ext    = {y[15], y};
    assign xy_diff  = x_ext - y_ext;
    assign abs_xy   = xy_diff[16] ? 17'(-xy_diff) : 17'(xy_diff);
    assign abs_x    = x[15] ? -x_ext : x_ext;

    // Change detection: an unset reference takes the current value first.
    assign diff_base = (word == MARKER_WORD) ? x : word;
    assign d         = $signed(16'(x - diff_base));
    assign d_ext     = {d[15], d};
    assign abs_d     = d[15] ? -d_ext : d_ext;

    always_comb
    begin
        if (stage_item_reg.function_code == FN_DIFF)
        begin
            if (!y[15])
            begin
                diff_hit = d >= y;
                diff_upd = d < 16'sd0;
            end
            else
            begin
                diff_hit = d <= y;
                diff_upd = d > 16'sd0;
            end
        end
        else
        begin
            diff_hit = abs_d >= y_ext;
            diff_upd = 1'b0;
        end
    end

    // Timer word: negative counts up through the on phase, positive counts down.
    assign on_ticks  = phase_ticks(stage_item_reg.on_delay_code);
    assign off_ticks = phase_ticks(stage_item_reg.off_delay_code);
    assign timer_inc = word + 16'd1;

    always_comb
    begin
        if (word == 16'd0 || word == MARKER_WORD)
        begin
            timer_next = 16'd0 - {4'b0, on_ticks};
        end
        else if (word[15])
        begin
            timer_next = (timer_inc == 16'd0) ? {4'b0, off_ticks} : timer_inc;
        end
        else
        begin
            timer_next = word - 16'd1;
        end
    end

    // Sticky word: low byte is the latch, bit 8 the last seen input level.
    assign sticky_st  = word[7:0];
    assign sticky_now = (sticky_st != 8'd0) ? stage_item_reg.second_bool
                                            : stage_item_reg.first_bool;

    always_comb
    begin
        sticky_last = word[15:8];
        sticky_next = word;
        if (sticky_now != sticky_last[0])
        begin
            sticky_next[15:8] = {sticky_last[7:1], ~sticky_last[0]};
            if (!sticky_last[0])
            begin
                sticky_next[7:0] = (sticky_st != 8'd0) ? 8'd0 : 8'd1;
            end
        end
    end

    assign gated = stage_item_reg.and_enabled && !stage_item_reg.and_state;

    always_comb
    begin
        eval_on   = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = x;
        clear_all = 1'b0;
        if (stage_valid_reg)
        begin
            priority if (stage_item_reg.action == ACT_CLEAR)
            begin
                clear_all = 1'b1;
            end
            else if (stage_item_reg.action == ACT_TICK)
            begin
                if (stage_item_reg.function_code == FN_TIMER)
                begin
                    mem_we    = in_range;
                    mem_wdata = timer_next;
                end
                else if (stage_item_reg.function_code == FN_STICKY)
                begin
                    mem_we    = in_range;
                    mem_wdata = sticky_next;
                end
            end
            else if (stage_item_reg.action == ACT_EVALUATE)
            begin
                if (stage_item_reg.function_code == FN_NONE
                    || stage_item_reg.function_code > FN_STICKY || gated)
                begin
                    // Drop to the marker; a sticky latch keeps its word.
                    mem_we    = in_range && (stage_item_reg.function_code != FN_STICKY);
                    mem_wdata = MARKER_WORD;
                end
                else
                begin
                    unique case (stage_item_reg.function_code)
                        FN_VEQUAL, FN_EQ: eval_on = x == y;
                        FN_ALMOST:
                            eval_on = stage_item_reg.exact_compare ? (x == y)
                                    : (abs_xy < {6'b0, margin_reg});
                        FN_VPOS, FN_GT: eval_on = x > y;
                        FN_VNEG, FN_LT: eval_on = x < y;
                        FN_APOS:  eval_on = abs_x > y_ext;
                        FN_ANEG:  eval_on = abs_x < y_ext;
                        FN_AND:   eval_on = stage_item_reg.first_bool
                                            && stage_item_reg.second_bool;
                        FN_OR:    eval_on = stage_item_reg.first_bool
                                            || stage_item_reg.second_bool;
                        FN_XOR:   eval_on = stage_item_reg.first_bool
                                            ^ stage_item_reg.second_bool;
                        FN_DIFF, FN_ADIFF:
                        begin
                            eval_on   = diff_hit;
                            mem_we    = in_range && ((word == MARKER_WORD)
                                                     || diff_hit || diff_upd);
                            mem_wdata = x;
                        end
                        FN_TIMER: eval_on = word[15] || (word == 16'd0);
                        default:  eval_on = word[0];
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SWITCH_COUNT; i++)
            begin
                mem_reg[i] <= MARKER_WORD;
            end
        end
        else if (clear_all)
        begin
            for (int i = 0; i < SWITCH_COUNT; i++)
            begin
                mem_reg[i] <= MARKER_WORD;
            end
        end
        else if (mem_we)
        begin
            mem_reg[stage_item_reg.switch_index] <= mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= stage_valid_reg && (stage_item_reg.action == ACT_EVALUATE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_valid_reg)
        begin
            result_reg.result_index <= stage_item_reg.switch_index;
            result_reg.switch_on    <= in_range && eval_on;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the logical switch evaluator: directed table, then random sessions.
module testbench;
    import lse_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int PHASE_WORDS    = 250;
    localparam int REPORT_CAP     = 40;

    typedef struct {
        item_t word;
        bit    pinned;
        bit    pinned_on;
    } plan_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    item_t               item;
    logic                result_valid;
    result_t             result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [MARGIN_W-1:0] cfg_data;

    // Predicted switch word file and margin
    logic [15:0]         switch_word [SWITCH_COUNT];
    logic [MARGIN_W-1:0] margin_model;

    result_t     awaited_states [$];
    plan_row_t   plan [$];
    int          mismatch_count;
    int          stall_cycles;
    int          calm_left;

    logical_switch_evaluator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_CAP)
            $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int phase_length(input logic signed [7:0] code);
        int c;
        c = code;
        if (c < -109)
            return 129 + c;
        if (c < 7)
            return (113 + c) * 5;
        return (53 + c) * 10;
    endfunction

    // Advance the predicted word file by one word; tell whether it yields a result.
    task automatic apply_word(input item_t w, output bit produces, output bit on);
        int          x;
        int          y;
        int          v;
        int          d;
        int          i;
        logic [15:0] cur;
        logic [15:0] delta;
        logic [7:0]  latch;
        logic [7:0]  level;
        bit          level_was;
        bit          level_now;
        bit          gated;
        bit          refresh;
        produces = 1'b0;
        on       = 1'b0;
        i        = w.switch_index;
        x        = $signed(w.source_value);
        y        = $signed(w.reference_value);
        cur      = switch_word[i];
        case (w.action)
            ACT_CLEAR:
                foreach (switch_word[k])
                    switch_word[k] = MARKER_WORD;
            ACT_TICK:
            begin
                if (w.function_code == FN_TIMER)
                begin
                    v = $signed(cur);
                    if (cur == 16'h0000 || cur == MARKER_WORD)
                        v = -phase_length(w.on_delay_code);
                    else if (v < 0)
                    begin
                        v++;
                        if (v == 0)
                            v = phase_length(w.off_delay_code);
                    end
                    else
                        v--;
                    switch_word[i] = v[15:0];
                end
                else if (w.function_code == FN_STICKY)
                begin
                    latch     = cur[7:0];
                    level     = cur[15:8];
                    level_was = level[0];
                    level_now = (latch != 8'd0) ? w.second_bool : w.first_bool;
                    // toggle on an input edge; only a rising edge flips the latch
                    if (level_now != level_was)
                    begin
                        level[0] = ~level[0];
                        if (!level_was)
                            latch = (latch != 8'd0) ? 8'd0 : 8'd1;
                    end
                    switch_word[i] = {level, latch};
                end
            end
            ACT_EVALUATE:
            begin
                produces = 1'b1;
                gated    = w.and_enabled && !w.and_state;
                if (w.function_code == FN_NONE || w.function_code > FN_STICKY || gated)
                begin
                    if (w.function_code != FN_STICKY)
                        switch_word[i] = MARKER_WORD;
                end
                else
                begin
                    case (w.function_code)
                        FN_VEQUAL, FN_EQ: on = (x == y);
                        FN_ALMOST:
                            on = w.exact_compare ? (x == y)
                                                 : (mag(x - y) < int'(margin_model));
                        FN_VPOS, FN_GT:   on = (x > y);
                        FN_VNEG, FN_LT:   on = (x < y);
                        FN_APOS:          on = (mag(x) > y);
                        FN_ANEG:          on = (mag(x) < y);
                        FN_AND:           on = w.first_bool & w.second_bool;
                        FN_OR:            on = w.first_bool | w.second_bool;
                        FN_XOR:           on = w.first_bool ^ w.second_bool;
                        FN_DIFF, FN_ADIFF:
                        begin
                            if (cur == MARKER_WORD)
                                cur = x[15:0];
                            delta   = x[15:0] - cur;
                            d       = $signed(delta);
                            refresh = 1'b0;
                            if (w.function_code == FN_DIFF)
                            begin
                                if (y >= 0)
                                begin
                                    on      = (d >= y);
                                    refresh = (d < 0);
                                end
                                else
                                begin
                                    on      = (d <= y);
                                    refresh = (d > 0);
                                end
                            end
                            else
                                on = (mag(d) >= y);
                            switch_word[i] = (on || refresh) ? x[15:0] : cur;
                        end
                        FN_TIMER:         on = ($signed(cur) <= 0);
                        default:          on = cur[0];
                    endcase
                end
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(49) == 0)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        case ($urandom_range(9))
            5, 6, 7, 8: return $urandom_range(1, 3);
            9:          return $urandom_range(6, 30);
            default:    return 0;
        endcase
    endfunction

    function automatic int pick_value();
        logic signed [15:0] r;
        case ($urandom_range(7))
            0:       return -32768;
            1:       return 32767;
            2:       return int'($urandom_range(2)) - 1;
            3, 4:    return int'($urandom_range(80)) - 40;
            default:
            begin
                r = 16'($urandom);
                return r;
            end
        endcase
    endfunction

    function automatic item_t mk(input logic [1:0] act, input int idx, input logic [4:0] fn,
                                 input int x, input int y);
        item_t w;
        w                 = '0;
        w.action          = act;
        w.switch_index    = idx[INDEX_W-1:0];
        w.function_code   = fn;
        w.source_value    = x[15:0];
        w.reference_value = y[15:0];
        return w;
    endfunction

    task automatic pin(input item_t w, input bit on);
        plan.push_back('{word: w, pinned: 1'b1, pinned_on: on});
    endtask

    task automatic note(input item_t w);
        plan.push_back('{word: w, pinned: 1'b0, pinned_on: 1'b0});
    endtask

    task automatic send_word(input item_t w, input bit pinned, input bit pinned_on);
        int      gap;
        bit      produces;
        bit      on;
        result_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            item  <= item_t'({$urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
        item  <= w;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        apply_word(w, produces, on);
        if (produces)
        begin
            r.result_index = w.switch_index;
            r.switch_on    = pinned ? pinned_on : on;
            awaited_states.push_back(r);
        end
    endtask

    // Write the margin only with nothing in flight.
    task automatic set_margin(input logic [MARGIN_W-1:0] m);
        start <= 1'b0;
        while (awaited_states.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        margin_model  = m;
    endtask

    // One burst on a single switch with one function, or one noise word.
    task automatic run_session(output int count);
        item_t             w;
        logic [3:0]        sw;
        logic [4:0]        fn;
        logic signed [7:0] on_code;
        logic signed [7:0] off_code;
        int                len;
        int                anchor;
        int                x;
        int                y;
        bit                timed;
        count = 0;
        if ($urandom_range(9) == 0)
        begin
            w = item_t'({$urandom, $urandom});
            send_word(w, 1'b0, 1'b0);
            count = (w.action != 2'd3);
            return;
        end
        sw = 4'($urandom);
        case ($urandom_range(19))
            17:      fn = FN_TIMER;
            18:      fn = FN_STICKY;
            19:      fn = FN_DIFF;
            default: fn = 5'($urandom_range(16));
        endcase
        timed    = (fn == FN_TIMER || fn == FN_STICKY);
        len      = timed ? $urandom_range(10, 40) : $urandom_range(3, 24);
        on_code  = ($urandom_range(4) != 0) ? 8'(int'($urandom_range(18)) - 128)
                                            : 8'($urandom);
        off_code = ($urandom_range(4) != 0) ? 8'(int'($urandom_range(18)) - 128)
                                            : 8'($urandom);
        anchor   = pick_value();
        repeat (len)
        begin
            if (timed)
                w = mk(($urandom_range(9) < 7) ? ACT_TICK : ACT_EVALUATE, sw, fn, 0, 0);
            else
                w = mk(($urandom_range(19) < 17) ? ACT_EVALUATE : ACT_TICK, sw, fn, 0, 0);
            if ($urandom_range(99) == 0)
                w.action = ACT_CLEAR;
            w.and_enabled   = ($urandom_range(3) == 0);
            w.and_state     = ($urandom_range(4) != 0);
            w.first_bool    = 1'($urandom);
            w.second_bool   = 1'($urandom);
            w.exact_compare = ($urandom_range(9) < 3);
            w.on_delay_code  = on_code;
            w.off_delay_code = off_code;
            case (fn)
                FN_DIFF, FN_ADIFF:
                begin
                    // walk near the last source value, jump now and then
                    anchor = ($urandom_range(7) == 0) ? pick_value()
                                                      : anchor + int'($urandom_range(60)) - 30;
                    x = anchor;
                    y = ($urandom_range(4) != 0) ? int'($urandom_range(50)) - 25 : pick_value();
                end
                FN_ALMOST:
                begin
                    x = pick_value();
                    y = x + int'($urandom_range(2 * margin_model + 4)) - int'(margin_model) - 2;
                end
                FN_VEQUAL, FN_EQ:
                begin
                    x = pick_value();
                    y = ($urandom_range(9) < 4) ? x : pick_value();
                end
                default:
                begin
                    x = pick_value();
                    y = pick_value();
                end
            endcase
            w.source_value    = x[15:0];
            w.reference_value = y[15:0];
            send_word(w, 1'b0, 1'b0);
            count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (awaited_states.size() == 0)
                report_mismatch($sformatf("result for switch %0d with no evaluation pending",
                                          result.result_index));
            else
            begin
                want = awaited_states.pop_front();
                if (result.result_index !== want.result_index)
                    report_mismatch($sformatf("result_index %0d, want %0d",
                                              result.result_index, want.result_index));
                if (result.switch_on !== want.switch_on)
                    report_mismatch($sformatf("switch %0d switch_on %0b, want %0b",
                                              want.result_index, result.switch_on,
                                              want.switch_on));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("logical_switch_evaluator verification failed");
            $finish;
        end
    end

    initial
    begin
        item_t w;
        int    sent;
        int    count;
        logic [MARGIN_W-1:0] phase_margin [5];
        start          <= 1'b0;
        item           <= '0;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        rst_n          <= 1'b0;
        calm_left       = 0;
        margin_model    = MARGIN_RESET;
        foreach (switch_word[k])
            switch_word[k] = MARKER_WORD;
        phase_margin = '{11'd1, 11'd1024, 11'($urandom_range(2, 1023)),
                         11'($urandom_range(1, 40)), 11'd16};

        pin(mk(ACT_EVALUATE, 0, FN_NONE, 5, 5), 1'b0);
        pin(mk(ACT_EVALUATE, 0, 5'd31, 5, 5), 1'b0);
        pin(mk(ACT_EVALUATE, 1, FN_VEQUAL, 32767, 32767), 1'b1);
        pin(mk(ACT_EVALUATE, 2, FN_VPOS, -32768, 32767), 1'b0);
        pin(mk(ACT_EVALUATE, 3, FN_VNEG, -32768, 32767), 1'b1);
        pin(mk(ACT_EVALUATE, 4, FN_ALMOST, 100, 115), 1'b1);
        w = mk(ACT_EVALUATE, 4, FN_ALMOST, 100, 115);
        w.exact_compare = 1'b1;
        pin(w, 1'b0);
        pin(mk(ACT_EVALUATE, 5, FN_APOS, -32768, 32767), 1'b1);
        pin(mk(ACT_EVALUATE, 6, FN_ANEG, -32768, -32768), 1'b0);
        w = mk(ACT_EVALUATE, 7, FN_AND, 0, 0);
        w.first_bool  = 1'b1;
        w.second_bool = 1'b1;
        pin(w, 1'b1);
        pin(mk(ACT_EVALUATE, 7, FN_OR, 0, 0), 1'b0);
        w = mk(ACT_EVALUATE, 7, FN_XOR, 0, 0);
        w.first_bool = 1'b1;
        pin(w, 1'b1);
        pin(mk(ACT_EVALUATE, 8, FN_EQ, -1, 0), 1'b0);
        pin(mk(ACT_EVALUATE, 8, FN_LT, -1, 0), 1'b1);
        w = mk(ACT_EVALUATE, 8, FN_VEQUAL, 7, 7);
        w.and_enabled = 1'b1;
        pin(w, 1'b0);
        pin(mk(ACT_EVALUATE, 9, FN_DIFF, 10, 5), 1'b0);
        note(mk(ACT_EVALUATE, 9, FN_DIFF, -32768, 100));
        note(mk(ACT_EVALUATE, 9, FN_ADIFF, 0, -5));
        pin(mk(ACT_EVALUATE, 10, FN_TIMER, 0, 0), 1'b1);
        w = mk(ACT_TICK, 10, FN_TIMER, 0, 0);
        w.on_delay_code  = -8'sd128;
        w.off_delay_code = 8'sd127;
        note(w);
        note(w);
        note(mk(ACT_EVALUATE, 10, FN_TIMER, 0, 0));
        w = mk(ACT_TICK, 11, FN_STICKY, 0, 0);
        w.first_bool = 1'b1;
        note(w);
        w = mk(ACT_EVALUATE, 11, FN_STICKY, 0, 0);
        w.and_enabled = 1'b1;
        pin(w, 1'b0);
        note(mk(ACT_EVALUATE, 11, FN_STICKY, 0, 0));
        note(mk(2'd3, 12, FN_VEQUAL, 0, 0));
        note(mk(ACT_CLEAR, 0, FN_NONE, 0, 0));
        pin(mk(ACT_EVALUATE, 10, FN_TIMER, 0, 0), 1'b1);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_margin(MARGIN_RESET);
        foreach (plan[n])
            send_word(plan[n].word, plan[n].pinned, plan[n].pinned_on);

        foreach (phase_margin[p])
        begin
            set_margin(phase_margin[p]);
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                run_session(count);
                sent += count;
            end
        end

        start <= 1'b0;
        while (awaited_states.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("logical_switch_evaluator verification clean");
        else
            $display("logical_switch_evaluator verification failed");
        $finish;
    end

endmodule
